[rtl/core/rgcp_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: shared package
// Types, register indexes, reset values and the divider step used by the
// colour pattern pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcp_pkg;

  localparam int unsigned CoordWidth   = 11;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned ColorWidth   = 32;
  localparam int unsigned CountWidth   = 8;
  localparam int unsigned FieldWidth   = 15;

  localparam logic [5:0] IndexedDepth = 6'd8;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PIXEL_DEPTH,
    REG_FIRST_COLOR,
    REG_COLOR_STEP,
    REG_RECT_COUNT,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_CHANNEL_SIZES,
    REG_CHANNEL_POSITIONS
  } cfg_reg_e;

  typedef logic [CoordWidth-1:0] coord_t;

  localparam logic [5:0]            RstPixelDepth  = 6'd8;
  localparam logic [ColorWidth-1:0] RstFirstColor  = 32'd0;
  localparam logic [7:0]            RstColorStep   = 8'd1;
  localparam logic [CountWidth-1:0] RstRectCount   = 8'd1;
  localparam coord_t                RstScreenW     = 11'd1024;
  localparam coord_t                RstScreenH     = 11'd768;
  localparam logic [11:0]           RstChanSizes   = 12'd2184;
  localparam logic [14:0]           RstChanPos     = 15'd4352;

  typedef struct packed {
    logic                  indexed;
    logic [ColorWidth-1:0] first_color;
    logic [7:0]            color_step;
    logic [CountWidth-1:0] rect_count;
    coord_t                rect_w;
    coord_t                rect_h;
    coord_t                lim_x;
    coord_t                lim_y;
    logic                  grid_ok;
    logic [11:0]           sizes;
    logic [14:0]           positions;
  } cfg_t;

  // One restoring division step: returns the new remainder and the quotient bit.
  function automatic logic [CoordWidth:0] div_step(coord_t rem, logic nbit, coord_t dvs);
    logic [CoordWidth:0] trial;
    logic [CoordWidth:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {diff[CoordWidth-1:0], 1'b1};
    end else begin
      div_step = {trial[CoordWidth-1:0], 1'b0};
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/rgcp_cfg.sv]
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: configuration registers
// Holds the registers and works out the rectangle size and the grid limits
// with a one-bit-per-cycle divider after every register write.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcp_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgcp_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [rgcp_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output      logic                                busy_o,
  output      rgcp_pkg::cfg_t                      cfg_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_LIM} state_e;

  state_e                              state_q;
  logic [5:0]                          depth_q;
  logic [rgcp_pkg::ColorWidth-1:0]     first_q;
  logic [7:0]                          step_q;
  logic [rgcp_pkg::CountWidth-1:0]     count_q;
  rgcp_pkg::coord_t                    width_q, height_q;
  logic [11:0]                         sizes_q;
  logic [14:0]                         pos_q;
  logic [3:0]                          bit_q;
  logic [rgcp_pkg::CountWidth-1:0]     rem_w_q, rem_h_q;
  rgcp_pkg::coord_t                    quo_w_q, quo_h_q;
  rgcp_pkg::coord_t                    lim_x_q, lim_y_q;
  logic                                grid_ok_q;

  logic [rgcp_pkg::CountWidth:0]       trial_w, trial_h;
  logic [rgcp_pkg::CountWidth:0]       diff_w, diff_h;
  logic [rgcp_pkg::CountWidth+rgcp_pkg::CoordWidth-1:0] prod_x, prod_y;
  rgcp_pkg::cfg_reg_e                  reg_sel;

  assign reg_sel = rgcp_pkg::cfg_reg_e'(cfg_idx_i);
  assign trial_w = {rem_w_q, width_q[bit_q]};
  assign trial_h = {rem_h_q, height_q[bit_q]};
  assign diff_w  = trial_w - {1'b0, count_q};
  assign diff_h  = trial_h - {1'b0, count_q};
  assign prod_x  = count_q * quo_w_q;
  assign prod_y  = count_q * quo_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      depth_q   <= rgcp_pkg::RstPixelDepth;
      first_q   <= rgcp_pkg::RstFirstColor;
      step_q    <= rgcp_pkg::RstColorStep;
      count_q   <= rgcp_pkg::RstRectCount;
      width_q   <= rgcp_pkg::RstScreenW;
      height_q  <= rgcp_pkg::RstScreenH;
      sizes_q   <= rgcp_pkg::RstChanSizes;
      pos_q     <= rgcp_pkg::RstChanPos;
      bit_q     <= '0;
      rem_w_q   <= '0;
      rem_h_q   <= '0;
      quo_w_q   <= rgcp_pkg::RstScreenW;
      quo_h_q   <= rgcp_pkg::RstScreenH;
      lim_x_q   <= rgcp_pkg::RstScreenW;
      lim_y_q   <= rgcp_pkg::RstScreenH;
      grid_ok_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_sel)
        rgcp_pkg::REG_PIXEL_DEPTH:       depth_q  <= cfg_data_i[5:0];
        rgcp_pkg::REG_FIRST_COLOR:       first_q  <= cfg_data_i[rgcp_pkg::ColorWidth-1:0];
        rgcp_pkg::REG_COLOR_STEP:        step_q   <= cfg_data_i[7:0];
        rgcp_pkg::REG_RECT_COUNT:        count_q  <= cfg_data_i[rgcp_pkg::CountWidth-1:0];
        rgcp_pkg::REG_SCREEN_WIDTH:      width_q  <= cfg_data_i[rgcp_pkg::CoordWidth-1:0];
        rgcp_pkg::REG_SCREEN_HEIGHT:     height_q <= cfg_data_i[rgcp_pkg::CoordWidth-1:0];
        rgcp_pkg::REG_CHANNEL_SIZES:     sizes_q  <= cfg_data_i[11:0];
        rgcp_pkg::REG_CHANNEL_POSITIONS: pos_q    <= cfg_data_i[14:0];
        default: ;
      endcase
      state_q <= ST_DIV;
      bit_q   <= 4'(rgcp_pkg::CoordWidth - 1);
      rem_w_q <= '0;
      rem_h_q <= '0;
    end else begin
      case (state_q)
        ST_DIV: begin
          if (trial_w >= {1'b0, count_q}) begin
            rem_w_q <= diff_w[rgcp_pkg::CountWidth-1:0];
            quo_w_q <= {quo_w_q[rgcp_pkg::CoordWidth-2:0], 1'b1};
          end else begin
            rem_w_q <= trial_w[rgcp_pkg::CountWidth-1:0];
            quo_w_q <= {quo_w_q[rgcp_pkg::CoordWidth-2:0], 1'b0};
          end
          if (trial_h >= {1'b0, count_q}) begin
            rem_h_q <= diff_h[rgcp_pkg::CountWidth-1:0];
            quo_h_q <= {quo_h_q[rgcp_pkg::CoordWidth-2:0], 1'b1};
          end else begin
            rem_h_q <= trial_h[rgcp_pkg::CountWidth-1:0];
            quo_h_q <= {quo_h_q[rgcp_pkg::CoordWidth-2:0], 1'b0};
          end
          if (bit_q == '0) begin
            state_q <= ST_LIM;
          end
          bit_q <= bit_q - 4'd1;
        end
        ST_LIM: begin
          lim_x_q   <= prod_x[rgcp_pkg::CoordWidth-1:0];
          lim_y_q   <= prod_y[rgcp_pkg::CoordWidth-1:0];
          grid_ok_q <= (count_q != '0) && (quo_w_q != '0) && (quo_h_q != '0);
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    cfg_o.indexed     = (depth_q == rgcp_pkg::IndexedDepth);
    cfg_o.first_color = first_q;
    cfg_o.color_step  = step_q;
    cfg_o.rect_count  = count_q;
    cfg_o.rect_w      = quo_w_q;
    cfg_o.rect_h      = quo_h_q;
    cfg_o.lim_x       = lim_x_q;
    cfg_o.lim_y       = lim_y_q;
    cfg_o.grid_ok     = grid_ok_q;
    cfg_o.sizes       = sizes_q;
    cfg_o.positions   = pos_q;
  end

endmodule

`default_nettype wire

[rtl/core/rgcp_grid.sv]
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: grid position pipeline
// Finds the rectangle column and row of a pixel with a pipelined restoring
// divider, three quotient bits per stage, and flags pixels off the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcp_grid (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire rgcp_pkg::coord_t                   x_i,
  input  wire rgcp_pkg::coord_t                   y_i,
  input  wire rgcp_pkg::cfg_t                     cfg_i,
  output      logic                               valid_o,
  output      logic                               inside_o,
  output      logic [rgcp_pkg::CountWidth-1:0]    col_o,
  output      logic [rgcp_pkg::CountWidth-1:0]    row_o
);

  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned NumStages =
      (rgcp_pkg::CoordWidth + StepsPerStage - 1) / StepsPerStage;

  typedef struct packed {
    logic             valid;
    logic             on_grid;
    rgcp_pkg::coord_t x;
    rgcp_pkg::coord_t y;
    rgcp_pkg::coord_t rem_x;
    rgcp_pkg::coord_t rem_y;
    rgcp_pkg::coord_t quo_x;
    rgcp_pkg::coord_t quo_y;
  } lane_t;

  lane_t stg_in [NumStages];
  lane_t stg_d  [NumStages];
  lane_t stg_q  [NumStages];

  always_comb begin
    stg_in[0].valid   = valid_i;
    stg_in[0].on_grid = cfg_i.grid_ok && (x_i < cfg_i.lim_x) && (y_i < cfg_i.lim_y);
    stg_in[0].x       = x_i;
    stg_in[0].y       = y_i;
    stg_in[0].rem_x   = '0;
    stg_in[0].rem_y   = '0;
    stg_in[0].quo_x   = '0;
    stg_in[0].quo_y   = '0;
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign stg_in[s] = stg_q[s-1];
    end

    always_comb begin
      logic [rgcp_pkg::CoordWidth:0] rx;
      logic [rgcp_pkg::CoordWidth:0] ry;
      int unsigned                   bi;
      stg_d[s] = stg_in[s];
      for (int unsigned k = 0; k < StepsPerStage; k++) begin
        if (s * StepsPerStage + k < rgcp_pkg::CoordWidth) begin
          bi = rgcp_pkg::CoordWidth - 1 - (s * StepsPerStage + k);
          rx = rgcp_pkg::div_step(stg_d[s].rem_x, stg_d[s].x[bi], cfg_i.rect_w);
          ry = rgcp_pkg::div_step(stg_d[s].rem_y, stg_d[s].y[bi], cfg_i.rect_h);
          stg_d[s].rem_x = rx[rgcp_pkg::CoordWidth:1];
          stg_d[s].rem_y = ry[rgcp_pkg::CoordWidth:1];
          stg_d[s].quo_x = {stg_d[s].quo_x[rgcp_pkg::CoordWidth-2:0], rx[0]};
          stg_d[s].quo_y = {stg_d[s].quo_y[rgcp_pkg::CoordWidth-2:0], ry[0]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[s] <= '0;
      end else if (en_i) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign valid_o  = stg_q[NumStages-1].valid;
  assign inside_o = stg_q[NumStages-1].on_grid;
  assign col_o    = stg_q[NumStages-1].quo_x[rgcp_pkg::CountWidth-1:0];
  assign row_o    = stg_q[NumStages-1].quo_y[rgcp_pkg::CountWidth-1:0];

endmodule

`default_nettype wire

[rtl/core/rgcp_color.sv]
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: colour stages
// Forms the palette index or advances the red, green and blue fields of the
// first colour (zero off the grid), then holds the word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcp_color (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic                               inside_i,
  input  wire logic [rgcp_pkg::CountWidth-1:0]    col_i,
  input  wire logic [rgcp_pkg::CountWidth-1:0]    row_i,
  input  wire rgcp_pkg::cfg_t                     cfg_i,
  output      logic                               valid_o,
  output      logic                               inside_o,
  output      logic [rgcp_pkg::ColorWidth-1:0]    color_o
);

  localparam int unsigned FW = rgcp_pkg::FieldWidth;

  logic                  prod_valid_q;
  logic                  prod_inside_q;
  logic [7:0]            idx_q;
  logic [15:0]           add_col_q, add_row_q;
  logic [FW-1:0]         ext_r_q, ext_g_q, ext_b_q;

  logic                  out_valid_q;
  logic                  out_inside_q;
  logic [rgcp_pkg::ColorWidth-1:0] color_q;

  logic [15:0]           idx_full;
  logic [15:0]           add_col_d, add_row_d;
  logic [4:0]            pos_r, pos_g, pos_b;
  logic [3:0]            size_r, size_g, size_b;
  logic [FW-1:0]         mask_r, mask_g, mask_b;
  logic [15:0]           add_sum;
  logic [15:0]           idx_step;
  logic [FW-1:0]         val_r, val_g, val_b;
  logic [rgcp_pkg::ColorWidth-1:0] color_d;

  assign size_r = cfg_i.sizes[11:8];
  assign size_g = cfg_i.sizes[7:4];
  assign size_b = cfg_i.sizes[3:0];
  assign pos_r  = cfg_i.positions[14:10];
  assign pos_g  = cfg_i.positions[9:5];
  assign pos_b  = cfg_i.positions[4:0];

  assign mask_r = FW'((16'd1 << size_r) - 16'd1);
  assign mask_g = FW'((16'd1 << size_g) - 16'd1);
  assign mask_b = FW'((16'd1 << size_b) - 16'd1);

  assign idx_full  = row_i * cfg_i.rect_count + {8'd0, col_i};
  assign add_col_d = col_i * cfg_i.color_step;
  assign add_row_d = row_i * cfg_i.color_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_inside_q <= inside_i;
      idx_q         <= idx_full[7:0];
      add_col_q     <= add_col_d;
      add_row_q     <= add_row_d;
      ext_r_q       <= FW'(cfg_i.first_color >> pos_r) & mask_r;
      ext_g_q       <= FW'(cfg_i.first_color >> pos_g) & mask_g;
      ext_b_q       <= FW'(cfg_i.first_color >> pos_b) & mask_b;
      out_inside_q  <= prod_inside_q;
      color_q       <= color_d;
    end
  end

  assign add_sum  = add_col_q + add_row_q;
  assign idx_step = idx_q * cfg_i.color_step;
  assign val_r    = (ext_r_q + add_col_q[FW-1:0]) & mask_r;
  assign val_g    = (ext_g_q + add_row_q[FW-1:0]) & mask_g;
  assign val_b    = (ext_b_q + add_sum[FW-1:0]) & mask_b;

  always_comb begin
    if (!prod_inside_q) begin
      color_d = '0;
    end else if (cfg_i.indexed) begin
      color_d = {24'd0, cfg_i.first_color[7:0] + idx_step[7:0]};
    end else begin
      color_d = ({17'd0, val_r} << pos_r)
              | ({17'd0, val_g} << pos_g)
              | ({17'd0, val_b} << pos_b);
    end
  end

  assign valid_o  = out_valid_q;
  assign inside_o = out_inside_q;
  assign color_o  = color_q;

endmodule

`default_nettype wire

[rtl/core/rectangle_grid_color_pattern.sv]
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: top level
// Streams pixel coordinates in and test pattern colours out.
// ----------------------------------------------------------------------------
// The block takes one pixel coordinate word per clock and returns one colour
// word per clock while the output is not stalled and no configuration update is
// running; each word passes four stages of the column and row divider, one
// stage of products and one output register. After every configuration write
// the input is held off while the rectangle size is divided out one bit per cycle and the grid
// limits are formed; write the registers before sending pixels.
`default_nettype none

module rectangle_grid_color_pattern (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgcp_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [rgcp_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [23:0]                         s_axis_tdata,  // pixel_x, pixel_y
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [31:0]                         m_axis_tdata,  // pixel_color
  output      logic                                m_axis_tuser   // inside_grid
);

  rgcp_pkg::cfg_t                    cfg;
  logic                              busy;
  logic                              en;
  logic                              grid_valid;
  logic                              grid_inside;
  logic [rgcp_pkg::CountWidth-1:0]   col;
  logic [rgcp_pkg::CountWidth-1:0]   row;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  rgcp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .cfg_o      (cfg)
  );

  rgcp_grid u_grid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid && s_axis_tready),
    .x_i      (s_axis_tdata[rgcp_pkg::CoordWidth-1:0]),
    .y_i      (s_axis_tdata[2*rgcp_pkg::CoordWidth-1:rgcp_pkg::CoordWidth]),
    .cfg_i    (cfg),
    .valid_o  (grid_valid),
    .inside_o (grid_inside),
    .col_o    (col),
    .row_o    (row)
  );

  rgcp_color u_color (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (grid_valid),
    .inside_i (grid_inside),
    .col_i    (col),
    .row_i    (row),
    .cfg_i    (cfg),
    .valid_o  (m_axis_tvalid),
    .inside_o (m_axis_tuser),
    .color_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[tb/sv/rectangle_grid_color_pattern_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle grid colour pattern: testbench
// Streams pixel coordinates through the block and compares every colour word
// and inside flag with a local model of the grid or a value typed in the
// directed table, in indexed and direct colour modes, across that table and
// randomly configured phases, with random stalls on both streams.
// ----------------------------------------------------------------------------

module rectangle_grid_color_pattern_tb;

  localparam int unsigned NumRows     = 37;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    rgcp_pkg::cfg_reg_e idx;
    logic [31:0]        value;
    rgcp_pkg::coord_t   x;
    rgcp_pkg::coord_t   y;
    logic               typed;
    logic [31:0]        color;
    logic               in_grid;
  } grid_row_t;

  typedef struct packed {
    logic [31:0] color;
    logic        in_grid;
  } pixel_out_t;

  typedef struct packed {
    logic [5:0]       depth;
    logic [31:0]      first;
    logic [7:0]       step;
    logic [7:0]       count;
    rgcp_pkg::coord_t width;
    rgcp_pkg::coord_t height;
    logic [11:0]      sizes;
    logic [14:0]      positions;
  } pattern_cfg_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel_x, pixel_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // pixel_color
  logic        m_axis_tuser;   // inside_grid

  pattern_cfg_t cfg_now;
  pixel_out_t   colors_due[$];
  pixel_out_t   want;
  int unsigned  errors;
  int unsigned  pixels_sent;
  int unsigned  colors_checked;
  int unsigned  inside_seen;
  int unsigned  direct_seen;
  int unsigned  writes_done;
  bit           src_calm;

  grid_row_t directed_rows [NumRows] = '{
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd0, 1'b1, 32'd0, 1'b1},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1023, 11'd767, 1'b1, 32'd0, 1'b1},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1024, 11'd0, 1'b1, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd768, 1'b1, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2047, 11'd2047, 1'b1, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_FIRST_COLOR, 32'hFFFF_FFFF, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_COLOR_STEP, 32'd255, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_RECT_COUNT, 32'd4, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd255, 11'd191, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1023, 11'd767, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_RECT_COUNT, 32'd0, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd0, 1'b1, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_RECT_COUNT, 32'd200, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_SCREEN_WIDTH, 32'd100, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd0, 1'b1, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_SCREEN_WIDTH, 32'd2047, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_SCREEN_HEIGHT, 32'd2047, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_RECT_COUNT, 32'd255, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2039, 11'd2039, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2040, 11'd0, 1'b1, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_PIXEL_DEPTH, 32'd32, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_FIRST_COLOR, 32'h1234_5678, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_COLOR_STEP, 32'd7, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2039, 11'd1030, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_CHANNEL_SIZES, 32'h80F, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_CHANNEL_POSITIONS, 32'h70A0, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1000, 11'd5, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2039, 11'd2039, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_PIXEL_DEPTH, 32'd63, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_CHANNEL_SIZES, 32'hFFF, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_CHANNEL_POSITIONS, 32'h7FFF, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd2039, 11'd17, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_WRITE, rgcp_pkg::REG_COLOR_STEP, 32'd0, 11'd0, 11'd0, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1, 11'd2, 1'b0, 32'd0, 1'b0},
    '{ROW_PIXEL, rgcp_pkg::REG_PIXEL_DEPTH, 32'd0, 11'd1234, 11'd987, 1'b0, 32'd0, 1'b0}
  };

  rectangle_grid_color_pattern dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] shift_channel(logic [31:0] base, logic [3:0] size,
                                                logic [4:0] pos, logic [31:0] add);
    logic [31:0] wrap;
    logic [31:0] mask;
    logic [31:0] v;
    wrap = (32'd1 << size) - 32'd1;
    mask = wrap << pos;
    v = (base & mask) >> pos;
    v = (v + add) & wrap;
    return (v << pos) & mask;
  endfunction

  function automatic pixel_out_t grid_color(rgcp_pkg::coord_t x, rgcp_pkg::coord_t y);
    int unsigned rw;
    int unsigned rh;
    int unsigned col;
    int unsigned row;
    pixel_out_t  res;
    res = '0;
    if (cfg_now.count != 0) begin
      rw = cfg_now.width / cfg_now.count;
      rh = cfg_now.height / cfg_now.count;
      if (rw != 0 && rh != 0) begin
        col = x / rw;
        row = y / rh;
        if (col < cfg_now.count && row < cfg_now.count) begin
          res.in_grid = 1'b1;
          if (cfg_now.depth == rgcp_pkg::IndexedDepth) begin
            res.color = (cfg_now.first + (row * cfg_now.count + col) * cfg_now.step) & 32'hFF;
          end else begin
            res.color =
              shift_channel(cfg_now.first, cfg_now.sizes[11:8], cfg_now.positions[14:10],
                            col * cfg_now.step) |
              shift_channel(cfg_now.first, cfg_now.sizes[7:4], cfg_now.positions[9:5],
                            row * cfg_now.step) |
              shift_channel(cfg_now.first, cfg_now.sizes[3:0], cfg_now.positions[4:0],
                            (col + row) * cfg_now.step);
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int unsigned pixel_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_pixel(rgcp_pkg::coord_t x, rgcp_pkg::coord_t y, bit typed,
                            pixel_out_t typed_out);
    int unsigned gap;
    pixel_out_t  due;
    gap = pixel_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    due = typed ? typed_out : grid_color(x, y);
    colors_due.push_back(due);
    pixels_sent++;
    if (due.in_grid) inside_seen++;
    if (due.in_grid && cfg_now.depth != rgcp_pkg::IndexedDepth) direct_seen++;
  endtask

  // Holds the coordinate stream back until every colour word has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colors_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(rgcp_pkg::cfg_reg_e r, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    writes_done++;
    case (r)
      rgcp_pkg::REG_PIXEL_DEPTH:       cfg_now.depth     = v[5:0];
      rgcp_pkg::REG_FIRST_COLOR:       cfg_now.first     = v;
      rgcp_pkg::REG_COLOR_STEP:        cfg_now.step      = v[7:0];
      rgcp_pkg::REG_RECT_COUNT:        cfg_now.count     = v[7:0];
      rgcp_pkg::REG_SCREEN_WIDTH:      cfg_now.width     = v[10:0];
      rgcp_pkg::REG_SCREEN_HEIGHT:     cfg_now.height    = v[10:0];
      rgcp_pkg::REG_CHANNEL_SIZES:     cfg_now.sizes     = v[11:0];
      rgcp_pkg::REG_CHANNEL_POSITIONS: cfg_now.positions = v[14:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (colors_due.size() == 0) begin
        $error("colour word with nothing expected: pixel_color %h inside_grid %b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = colors_due.pop_front();
        colors_checked++;
        if (m_axis_tdata !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.in_grid) begin
          $error("inside_grid: expected %b, got %b", want.in_grid, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin : sink
    int unsigned stall_left;
    int unsigned r;
    int unsigned cycles;
    bit          sink_calm;
    stall_left = 0;
    cycles     = 0;
    sink_calm  = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles % 300 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (sink_calm || r >= 20) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left = (r < 17) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned      r;
    int unsigned      span;
    rgcp_pkg::coord_t x;
    rgcp_pkg::coord_t y;
    logic [5:0]       depth;
    logic [7:0]       count;
    rgcp_pkg::coord_t width;
    rgcp_pkg::coord_t height;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= rgcp_pkg::REG_PIXEL_DEPTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    errors         = 0;
    pixels_sent    = 0;
    colors_checked = 0;
    inside_seen    = 0;
    direct_seen    = 0;
    writes_done    = 0;
    src_calm       = 1'b0;
    cfg_now = '{rgcp_pkg::RstPixelDepth, rgcp_pkg::RstFirstColor, rgcp_pkg::RstColorStep,
                rgcp_pkg::RstRectCount, rgcp_pkg::RstScreenW, rgcp_pkg::RstScreenH,
                rgcp_pkg::RstChanSizes, rgcp_pkg::RstChanPos};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
                   '{directed_rows[i].color, directed_rows[i].in_grid});
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      src_calm = (p % 3 == 1);
      if (p % 2 == 0) depth = rgcp_pkg::IndexedDepth;
      else if (p == 1) depth = 6'd63;
      else if (p == 3) depth = 6'd0;
      else depth = 6'($urandom_range(0, 63));
      if (p == 2) count = 8'd255;
      else if (p >= 6) count = 8'd1;
      else if ($urandom_range(0, 7) == 0) count = 8'($urandom_range(0, 255));
      else count = 8'($urandom_range(1, 12));
      width  = (p == 2) ? 11'd2047 : (p == 6) ? 11'd1 : 11'($urandom_range(1, 2047));
      height = (p == 2) ? 11'd2047 : (p == 7) ? 11'd1 : 11'($urandom_range(1, 2047));
      write_reg(rgcp_pkg::REG_PIXEL_DEPTH, 32'(depth));
      write_reg(rgcp_pkg::REG_FIRST_COLOR, (p == 4) ? 32'hFFFF_FFFF : 32'($urandom));
      write_reg(rgcp_pkg::REG_COLOR_STEP, (p == 0) ? 32'd0 : (p == 1) ? 32'd255
                                                  : 32'($urandom_range(0, 255)));
      write_reg(rgcp_pkg::REG_RECT_COUNT, 32'(count));
      write_reg(rgcp_pkg::REG_SCREEN_WIDTH, 32'(width));
      write_reg(rgcp_pkg::REG_SCREEN_HEIGHT, 32'(height));
      write_reg(rgcp_pkg::REG_CHANNEL_SIZES, 32'($urandom_range(0, 4095)));
      write_reg(rgcp_pkg::REG_CHANNEL_POSITIONS, 32'($urandom_range(0, 32767)));
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(0, 3);
        span = (r == 0) ? 2047 : (cfg_now.width > 1 ? cfg_now.width - 1 : 1);
        x = rgcp_pkg::coord_t'($urandom_range(0, span));
        span = (r == 0) ? 2047 : (cfg_now.height > 1 ? cfg_now.height - 1 : 1);
        y = rgcp_pkg::coord_t'($urandom_range(0, span));
        if ($urandom_range(0, 59) == 0) settle();
        push_pixel(x, y, 1'b0, '0);
      end
    end

    settle();
    $display("%0d coordinate words sent over %0d register writes, %0d colour words checked.",
             pixels_sent, writes_done, colors_checked);
    $display("%0d pixels fell inside the grid, %0d of them in direct colour mode.",
             inside_seen, direct_seen);
    if (errors == 0 && colors_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
